/* rtl/nfst_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfst_pkg
// Shared types and constants of the frame sync tracker.
// ----------------------------------------------------------------------------
package nfst_pkg;

	localparam int MAX_SLIP        = 128;
	localparam int LOST_LIMIT      = 4;
	localparam int FRAME_SUBFRAMES = 10;
	localparam int OFF_LIMIT       = 30720;

	localparam int DIVN_W  = 48;
	localparam int DIVD_W  = 19;
	localparam int DIVC_W  = 6;
	localparam int MULC_W  = 5;
	localparam int MULP_W  = 17;
	localparam int MULA_W  = 67;
	localparam int CFG_W   = 17;
	localparam int CFGI_W  = 4;

	localparam logic [1:0] OUTC_NONE   = 2'd0;
	localparam logic [1:0] OUTC_FOUND  = 2'd1;
	localparam logic [1:0] OUTC_NOROOM = 2'd2;
	localparam logic [1:0] OUTC_ERROR  = 2'd3;

	localparam logic [1:0] ST_NOSYNC = 2'd0;
	localparam logic [1:0] ST_SYNC   = 2'd1;
	localparam logic [1:0] ST_ERR    = 2'd2;

	localparam logic [CFGI_W-1:0] CFG_SF_LEN   = 4'd0;
	localparam logic [CFGI_W-1:0] CFG_FFT_LEN  = 4'd1;
	localparam logic [CFGI_W-1:0] CFG_CORR_OFF = 4'd2;
	localparam logic [CFGI_W-1:0] CFG_OFF_PER  = 4'd3;
	localparam logic [CFGI_W-1:0] CFG_SFO_W    = 4'd4;
	localparam logic [CFGI_W-1:0] CFG_FIND_AVG = 4'd5;
	localparam logic [CFGI_W-1:0] CFG_AGC_EN   = 4'd6;
	localparam logic [CFGI_W-1:0] CFG_AGC_PER  = 4'd7;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_DIV_GO,
		S_DIV_WAIT,
		S_TRK,
		S_ADJ,
		S_MUL_GO,
		S_MUL_WAIT,
		S_FEND,
		S_FIN
	} state_t;

	typedef enum logic [2:0] {
		DOP_FIND,
		DOP_AGC,
		DOP_PHASE,
		DOP_TERM,
		DOP_MEAN
	} div_op_t;

	typedef struct packed {
		logic    load;
		logic    decide;
		logic    trk;
		logic    div_start;
		logic    div_take;
		logic    adj;
		logic    mul_start;
		logic    mul_take;
		logic    fend;
		logic    fin;
		div_op_t div_op;
	} cmd_t;

	typedef struct packed {
		logic       track;
		logic [1:0] outc;
		logic       sf5;
		logic       find_div;
		logic       agc_div;
		logic       period_nz;
		logic       phase_zero;
		logic       div_done;
		logic       mul_done;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/nfst_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfst_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nfst_div import nfst_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVN_W-1:0] dividend,
	input  wire logic [DIVD_W-1:0] divisor,
	output logic      [DIVN_W-1:0] quotient,
	output logic      [DIVD_W-1:0] remainder,
	output logic                   done
);

	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] dvs_q;
	logic [DIVC_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIVD_W:0]   rem_sh;
	logic [DIVD_W:0]   rem_nx;
	logic              ge;

	always_comb begin
		rem_sh = {rem_q, quo_q[DIVN_W-1]};
		ge     = rem_sh >= {1'b0, dvs_q};
		rem_nx = ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIVC_W'(DIVN_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVN_W-2:0], ge};
			rem_q <= rem_nx[DIVD_W-1:0];
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule
`default_nettype wire

/* rtl/nfst_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfst_ctrl
// Sequencer: steps the datapath through one item and owns the handshakes.
// ----------------------------------------------------------------------------
module nfst_ctrl import nfst_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  in_valid,
	output logic       in_stall,
	output logic       out_valid,
	input  wire logic  out_stall,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	state_t  state_q, state_d;
	div_op_t op_q, op_d;
	logic    out_valid_q;
	logic    out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_DECIDE;
			S_DECIDE: begin
				if (!stat.track) begin
					if (stat.find_div) begin
						state_d = S_DIV_GO;
						op_d    = DOP_FIND;
					end else begin
						state_d = S_FIN;
					end
				end else if (stat.sf5) begin
					if (stat.agc_div) begin
						state_d = S_DIV_GO;
						op_d    = DOP_AGC;
					end else begin
						state_d = S_TRK;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_DIV_GO: state_d = S_DIV_WAIT;
			S_DIV_WAIT: begin
				if (stat.div_done) begin
					unique case (op_q)
						DOP_FIND: state_d = S_FIN;
						DOP_AGC:  state_d = S_TRK;
						DOP_PHASE: begin
							state_d = S_DIV_GO;
							op_d    = DOP_TERM;
						end
						DOP_TERM: state_d = stat.phase_zero ? S_ADJ : S_FEND;
						DOP_MEAN: state_d = S_MUL_GO;
						default:  state_d = S_FIN;
					endcase
				end
			end
			S_TRK: begin
				if (stat.outc == OUTC_FOUND) begin
					if (stat.period_nz) begin
						state_d = S_DIV_GO;
						op_d    = DOP_PHASE;
					end else begin
						state_d = S_ADJ;
					end
				end else begin
					state_d = S_FIN;
				end
			end
			S_ADJ: begin
				if (stat.period_nz) begin
					state_d = S_DIV_GO;
					op_d    = DOP_MEAN;
				end else begin
					state_d = S_MUL_GO;
				end
			end
			S_MUL_GO:   state_d = S_MUL_WAIT;
			S_MUL_WAIT: if (stat.mul_done) state_d = S_FEND;
			S_FEND:     state_d = S_FIN;
			S_FIN:      if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.div_op    = op_q;
		cmd.load      = (state_q == S_IDLE) && in_valid;
		cmd.decide    = (state_q == S_DECIDE);
		cmd.trk       = (state_q == S_TRK);
		cmd.div_start = (state_q == S_DIV_GO);
		cmd.div_take  = (state_q == S_DIV_WAIT) && stat.div_done;
		cmd.adj       = (state_q == S_ADJ);
		cmd.mul_start = (state_q == S_MUL_GO);
		cmd.mul_take  = (state_q == S_MUL_WAIT) && stat.mul_done;
		cmd.fend      = (state_q == S_FEND);
		cmd.fin       = (state_q == S_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= DOP_FIND;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.fin)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/nfst_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nfst_dp
// Datapath: configuration, tracker state, offset arithmetic and result register.
// ----------------------------------------------------------------------------
module nfst_dp import nfst_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CFGI_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	input  wire logic [1:0]        sync_outcome,
	input  wire logic [18:0]       peak_position,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	output logic [1:0]             sync_status,
	output logic                   tracking_mode,
	output logic [3:0]             subframe_index,
	output logic [18:0]            drop_samples,
	output logic [18:0]            next_receive_length,
	output logic                   correlate_next,
	output logic                   agc_now,
	output logic signed [15:0]     last_offset,
	output logic signed [31:0]     sfo_estimate_q16
);

	// configuration
	logic [14:0] sl_q, coff_q;
	logic [11:0] fft_q;
	logic [10:0] oper_q, agcper_q;
	logic [16:0] w_q;
	logic [3:0]  fav_q;
	logic        agcen_q;

	// tracker state
	logic               track_q;
	logic [3:0]         sf_q, hits_q;
	logic [31:0]        good_q, tframes_q;
	logic [2:0]         missed_q;
	logic signed [47:0] accum_q;
	logic signed [31:0] sfo_q;
	logic signed [15:0] lastoff_q;

	// per-item working registers
	logic [1:0]         outc_q;
	logic [18:0]        peak_q;
	logic [1:0]         status_q;
	logic [18:0]        drop_q;
	logic               agc_q;
	logic signed [19:0] slip_q;
	logic               phase_zero_q;
	logic signed [19:0] adj_q;
	logic signed [48:0] mean_q;
	logic signed [31:0] ema_q;

	// serial multiplier
	logic [MULA_W-1:0] mcand_q, macc_q;
	logic [MULP_W-1:0] mplier_q;
	logic [MULC_W-1:0] mcnt_q;
	logic              mbusy_q, mdone_q;
	logic              dneg_q;

	// result register
	logic [1:0]         ro_status_q;
	logic               ro_track_q;
	logic [3:0]         ro_sf_q;
	logic [18:0]        ro_drop_q, ro_nlen_q;
	logic               ro_corr_q, ro_agc_q;
	logic signed [15:0] ro_off_q;
	logic signed [31:0] ro_sfo_q;

	// divider
	logic [DIVN_W-1:0] div_n, div_q;
	logic [DIVD_W-1:0] div_d, div_r;
	logic              div_done;
	logic [DIVN_W-1:0] q_rnd;

	logic [18:0]        flen_frame, half_frame, flen_cur;
	logic [3:0]         hits_inc, sf_next;
	logic [2:0]         missed_inc;
	logic               realign;
	logic signed [20:0] diff_pk, d_find;
	logic [20:0]        dfind_mag;
	logic signed [15:0] d_clamp;
	logic [15:0]        loff_mag;
	logic [47:0]        accum_mag;
	logic [18:0]        find_drop;
	logic signed [48:0] term, sum49;
	logic signed [47:0] accum_sat;
	logic [48:0]        arnd_sum;
	logic signed [33:0] arnd;
	logic signed [19:0] adj_c;
	logic signed [49:0] diff50;
	logic [49:0]        diff_mag;
	logic [16:0]        w_eff;
	logic [MULA_W:0]    e_sum;
	logic signed [52:0] e_s;
	logic signed [53:0] s54;
	logic signed [31:0] ema_c;
	logic signed [19:0] a_fin;
	logic [19:0]        slip_mag;
	logic [18:0]        slip_min;

	always_comb begin
		flen_frame = 19'(19'(sl_q) * 19'(FRAME_SUBFRAMES));
		half_frame = 19'(19'(sl_q) * 19'(FRAME_SUBFRAMES / 2));
		hits_inc   = (hits_q == 4'hF) ? hits_q : hits_q + 4'd1;
		missed_inc = (missed_q == 3'h7) ? missed_q : missed_q + 3'd1;
		sf_next    = (sf_q >= 4'(FRAME_SUBFRAMES - 1)) ? 4'd0 : sf_q + 4'd1;
		realign    = (outc_q == OUTC_FOUND) &&
		             ((hits_inc >= fav_q) || (peak_q < {6'b0, fft_q, 1'b0}));
		diff_pk    = $signed({2'b0, peak_q}) - $signed({6'b0, coff_q});
		d_find     = diff_pk + $signed({2'b0, half_frame});
		dfind_mag  = d_find[20] ? 21'(-d_find) : 21'(d_find);
		if (diff_pk > 21'sd30720)
			d_clamp = 16'(OFF_LIMIT);
		else if (diff_pk < -21'sd30720)
			d_clamp = -16'(OFF_LIMIT);
		else
			d_clamp = diff_pk[15:0];
		loff_mag  = lastoff_q[15] ? 16'(-lastoff_q) : 16'(lastoff_q);
		accum_mag = accum_q[47] ? 48'(-accum_q) : 48'(accum_q);
	end

	// divider operand selection
	always_comb begin
		case (cmd.div_op)
			DOP_FIND: begin
				div_n = 48'(dfind_mag);
				div_d = flen_frame;
			end
			DOP_AGC: begin
				div_n = 48'(tframes_q);
				div_d = 19'(agcper_q);
			end
			DOP_PHASE: begin
				div_n = 48'(good_q);
				div_d = 19'(oper_q);
			end
			DOP_TERM: begin
				div_n = {16'b0, loff_mag, 16'b0};
				div_d = 19'(oper_q);
			end
			DOP_MEAN: begin
				div_n = accum_mag;
				div_d = 19'(oper_q);
			end
			default: begin
				div_n = '0;
				div_d = '0;
			end
		endcase
	end

	nfst_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (div_n),
		.divisor   (div_d),
		.quotient  (div_q),
		.remainder (div_r),
		.done      (div_done)
	);

	always_comb begin
		// round to nearest, halves away from zero
		q_rnd = div_q + 48'({div_r, 1'b0} >= {1'b0, div_d});
		// true non-negative modulo for the realign drop
		if (d_find[20] && div_r != '0)
			find_drop = flen_frame - div_r;
		else
			find_drop = div_r;
		term  = lastoff_q[15] ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});
		sum49 = $signed({accum_q[47], accum_q}) + term;
		if (sum49[48] != sum49[47])
			accum_sat = sum49[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
		else
			accum_sat = sum49[47:0];
		arnd_sum = {1'b0, accum_mag} + 49'd32768;
		arnd     = accum_q[47] ? -$signed({1'b0, arnd_sum[48:16]})
		                       : $signed({1'b0, arnd_sum[48:16]});
		if (arnd > 34'sd524287)
			adj_c = 20'sd524287;
		else if (arnd < -34'sd524288)
			adj_c = -20'sd524288;
		else
			adj_c = arnd[19:0];
		diff50   = $signed({mean_q[48], mean_q}) - 50'(sfo_q);
		diff_mag = diff50[49] ? 50'(-diff50) : 50'(diff50);
		w_eff    = (w_q > 17'd65536) ? 17'd65536 : w_q;
		e_sum    = {1'b0, macc_q} + (MULA_W + 1)'(32768);
		e_s      = dneg_q ? -$signed({1'b0, e_sum[MULA_W:16]})
		                  : $signed({1'b0, e_sum[MULA_W:16]});
		s54      = 54'(sfo_q) + 54'(e_s);
		if (s54 > 54'sd2147483647)
			ema_c = 32'sh7FFFFFFF;
		else if (s54 < -54'sd2147483648)
			ema_c = 32'sh80000000;
		else
			ema_c = s54[31:0];
		a_fin    = phase_zero_q ? adj_q : 20'sd0;
		flen_cur = track_q ? 19'(sl_q) : flen_frame;
		slip_mag = slip_q[19] ? 20'(-slip_q) : 20'(slip_q);
		slip_min = (slip_mag > {1'b0, flen_cur}) ? flen_cur : slip_mag[18:0];
	end

	always_comb begin
		stat            = '0;
		stat.track      = track_q;
		stat.outc       = outc_q;
		stat.sf5        = (sf_next == 4'd5);
		stat.find_div   = realign && (flen_frame != '0);
		stat.agc_div    = agcen_q && (agcper_q != '0);
		stat.period_nz  = (oper_q != '0);
		stat.phase_zero = phase_zero_q;
		stat.div_done   = div_done;
		stat.mul_done   = mdone_q;
	end

	// configuration and tracker state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sl_q      <= 15'd1920;
			fft_q     <= 12'd128;
			coff_q    <= '0;
			oper_q    <= 11'd10;
			w_q       <= 17'd6554;
			fav_q     <= 4'd1;
			agcen_q   <= 1'b0;
			agcper_q  <= '0;
			track_q   <= 1'b0;
			sf_q      <= '0;
			hits_q    <= '0;
			good_q    <= '0;
			missed_q  <= '0;
			tframes_q <= '0;
			accum_q   <= '0;
			sfo_q     <= '0;
			lastoff_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SF_LEN:   sl_q     <= cfg_data[14:0];
					CFG_FFT_LEN:  fft_q    <= cfg_data[11:0];
					CFG_CORR_OFF: coff_q   <= cfg_data[14:0];
					CFG_OFF_PER:  oper_q   <= cfg_data[10:0];
					CFG_SFO_W:    w_q      <= cfg_data;
					CFG_FIND_AVG: fav_q    <= cfg_data[3:0];
					CFG_AGC_EN:   agcen_q  <= cfg_data[0];
					CFG_AGC_PER:  agcper_q <= cfg_data[10:0];
					default: ;
				endcase
			end
			if (cmd.decide) begin
				if (!track_q) begin
					if (outc_q == OUTC_FOUND) begin
						if (realign) begin
							good_q    <= '0;
							missed_q  <= '0;
							tframes_q <= '0;
							hits_q    <= '0;
							accum_q   <= '0;
							sf_q      <= 4'd9;
							track_q   <= 1'b1;
						end else begin
							hits_q <= hits_inc;
							sf_q   <= 4'd5;
						end
					end
				end else begin
					sf_q <= sf_next;
				end
			end
			if (cmd.trk) begin
				unique case (outc_q)
					OUTC_ERROR: ;
					OUTC_NOROOM: begin
						track_q   <= 1'b0;
						tframes_q <= tframes_q + 32'd1;
					end
					OUTC_NONE: begin
						missed_q <= missed_inc;
						if (missed_inc >= 3'(LOST_LIMIT))
							track_q <= 1'b0;
						tframes_q <= tframes_q + 32'd1;
					end
					OUTC_FOUND: begin
						tframes_q <= tframes_q + 32'd1;
						lastoff_q <= d_clamp;
						if (oper_q == '0)
							accum_q <= {{16{d_clamp[15]}}, d_clamp, 16'b0};
					end
					default: ;
				endcase
			end
			if (cmd.div_take && cmd.div_op == DOP_TERM)
				accum_q <= accum_sat;
			if (cmd.fend) begin
				if (phase_zero_q) begin
					sfo_q   <= ema_q;
					accum_q <= '0;
				end
				good_q <= good_q + 32'd1;
			end
		end
	end

	// per-item working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			outc_q <= sync_outcome;
			peak_q <= peak_position;
		end
		if (cmd.decide) begin
			slip_q <= '0;
			if (!track_q) begin
				status_q <= (outc_q == OUTC_ERROR) ? ST_ERR : ST_NOSYNC;
				agc_q    <= (outc_q == OUTC_ERROR) ? 1'b0 : agcen_q;
				drop_q   <= (outc_q == OUTC_NOROOM) ? half_frame : '0;
			end else begin
				status_q <= ST_SYNC;
				drop_q   <= '0;
				agc_q    <= (sf_next == 4'd5) && agcen_q && (agcper_q == '0);
			end
		end
		if (cmd.trk) begin
			unique case (outc_q)
				OUTC_ERROR:  status_q <= ST_ERR;
				OUTC_NOROOM: status_q <= ST_NOSYNC;
				OUTC_NONE:   if (missed_inc >= 3'(LOST_LIMIT)) status_q <= ST_NOSYNC;
				OUTC_FOUND:  phase_zero_q <= 1'b1;
				default: ;
			endcase
		end
		if (cmd.div_take) begin
			case (cmd.div_op)
				DOP_FIND:  drop_q       <= find_drop;
				DOP_AGC:   agc_q        <= (div_r == '0);
				DOP_PHASE: phase_zero_q <= (div_r == '0);
				DOP_MEAN:  mean_q       <= accum_q[47] ? -$signed({1'b0, q_rnd})
				                                       : $signed({1'b0, q_rnd});
				default: ;
			endcase
		end
		if (cmd.adj) begin
			adj_q  <= adj_c;
			mean_q <= {accum_q[47], accum_q};
		end
		if (cmd.mul_take)
			ema_q <= ema_c;
		if (cmd.fend) begin
			if (a_fin > 20'sd0 && a_fin < 20'(MAX_SLIP)) begin
				drop_q <= 19'(a_fin);
				slip_q <= '0;
			end else begin
				slip_q <= a_fin;
			end
		end
	end

	// shift-add multiplier for the sfo update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			mdone_q <= 1'b0;
			mcnt_q  <= '0;
		end else begin
			mdone_q <= 1'b0;
			if (cmd.mul_start) begin
				mbusy_q <= 1'b1;
				mcnt_q  <= '0;
			end else if (mbusy_q) begin
				mcnt_q <= mcnt_q + 1'b1;
				if (mcnt_q == MULC_W'(MULP_W - 1)) begin
					mbusy_q <= 1'b0;
					mdone_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			mcand_q  <= MULA_W'(diff_mag);
			mplier_q <= w_eff;
			macc_q   <= '0;
			dneg_q   <= diff50[49];
		end else if (mbusy_q) begin
			if (mplier_q[0])
				macc_q <= macc_q + mcand_q;
			mcand_q  <= {mcand_q[MULA_W-2:0], 1'b0};
			mplier_q <= {1'b0, mplier_q[MULP_W-1:1]};
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			ro_status_q <= status_q;
			ro_track_q  <= track_q;
			ro_sf_q     <= sf_q;
			ro_drop_q   <= drop_q;
			ro_nlen_q   <= flen_cur - slip_min;
			ro_corr_q   <= track_q ? (sf_q == 4'd4) : 1'b1;
			ro_agc_q    <= agc_q;
			ro_off_q    <= lastoff_q;
			ro_sfo_q    <= sfo_q;
		end
	end

	assign sync_status         = ro_status_q;
	assign tracking_mode       = ro_track_q;
	assign subframe_index      = ro_sf_q;
	assign drop_samples        = ro_drop_q;
	assign next_receive_length = ro_nlen_q;
	assign correlate_next      = ro_corr_q;
	assign agc_now             = ro_agc_q;
	assign last_offset         = ro_off_q;
	assign sfo_estimate_q16    = ro_sfo_q;

endmodule
`default_nettype wire

/* rtl/nbiot_frame_sync_tracker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// nbiot_frame_sync_tracker
// Find/track timing controller for the narrowband downlink receive chain.
// ----------------------------------------------------------------------------
// One item is one received block with the correlator outcome and peak position;
// it gives one result item. The block works on one item at a time. A plain
// block steps through accept, decide and result load. A find peak that
// realigns, or a subframe 5 whose gain decision needs a modulo, adds one pass
// of the shared radix-2 divider, with its start and hand-off states.
// A found peak on subframe 5 can take up to four divider passes (gain modulo,
// phase, per-step offset term, mean) plus a serial multiply, with hand-off,
// for the sfo average. A finished result waits in an output register; the
// next item is taken once the result has been loaded there.
// ----------------------------------------------------------------------------
module nbiot_frame_sync_tracker import nfst_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write port
	input  wire logic              cfg_we,
	input  wire logic [CFGI_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_data,
	// input item channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        sync_outcome,
	input  wire logic [18:0]       peak_position,
	// result item channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             sync_status,
	output logic                   tracking_mode,
	output logic [3:0]             subframe_index,
	output logic [18:0]            drop_samples,
	output logic [18:0]            next_receive_length,
	output logic                   correlate_next,
	output logic                   agc_now,
	output logic signed [15:0]     last_offset,
	output logic signed [31:0]     sfo_estimate_q16
);

	cmd_t  cmd;   // sequencer commands
	stat_t stat;  // datapath status back to the sequencer

	// sequencer: one state per arithmetic step of an item
	nfst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// datapath: config, tracker state, divider, multiplier, result register
	nfst_dp u_dp (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_we              (cfg_we),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.sync_outcome        (sync_outcome),
		.peak_position       (peak_position),
		.cmd                 (cmd),
		.stat                (stat),
		.sync_status         (sync_status),
		.tracking_mode       (tracking_mode),
		.subframe_index      (subframe_index),
		.drop_samples        (drop_samples),
		.next_receive_length (next_receive_length),
		.correlate_next      (correlate_next),
		.agc_now             (agc_now),
		.last_offset         (last_offset),
		.sfo_estimate_q16    (sfo_estimate_q16)
	);

endmodule
`default_nettype wire
